[rtl/core/ldws_pkg.sv]
// Shared types and constants for the loop-duration window statistics block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ldws_pkg;

  // Width of timestamps, durations and all statistics
  localparam int unsigned DataW = 32;
  typedef logic [DataW-1:0] word_t;

  // Number of statistics windows: short and long
  localparam int unsigned NumWin = 2;
  localparam int unsigned WinIdxW = $clog2(NumWin);
  typedef logic [WinIdxW-1:0] win_idx_t;
  localparam win_idx_t WinShort = WinIdxW'(0);
  localparam win_idx_t WinLong  = WinIdxW'(1);

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Serial divider: one quotient bit per cycle
  localparam int unsigned DivCntW = $clog2(DataW);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DataW - 1);

  // Register reset values
  localparam word_t ShortPeriodRst = 32'd1000000;
  localparam word_t LongPeriodRst  = 32'd10000000;
  localparam word_t AllOnes        = 32'hFFFF_FFFF;

  // Item command
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    REG_SHORT_PERIOD = 1'b0,
    REG_LONG_PERIOD  = 1'b1
  } reg_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_e  cmd;
    word_t stamp;
    word_t duration;
  } item_t;

  // Divider request and response
  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/loop_duration_window_stats_top.sv]
// Top level of the loop-duration window statistics block.
// Depends on ldws_pkg, ldws_front, ldws_fifo, ldws_back and ldws_div.
//
// Each input beat carries a command (tick or start) and a 32-bit microsecond
// timestamp and produces exactly one result beat. A start beat only records its
// timestamp; a tick beat also folds its duration into both windows, and each
// window (short, long) that closes on it computes its average sum/count through
// one shared restoring divider that yields one quotient bit per cycle. The front
// end measures durations on acceptance and a two-entry queue buffers beats, so
// while the queue has room the input keeps taking beats as the back end works or
// a result waits in the output register. Write the period registers only while
// the block is idle.
`default_nettype none

module loop_duration_window_stats_top import ldws_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_index_i,
  input  wire word_t cfg_data_i,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire logic  cmd_i,
  input  wire word_t stamp_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output word_t      duration_o,
  output word_t      short_min_o,
  output word_t      short_avg_o,
  output word_t      short_max_o,
  output word_t      long_min_o,
  output word_t      long_avg_o,
  output word_t      long_max_o,
  output word_t      all_min_o,
  output word_t      all_max_o
);

  logic     q_full, q_push, q_valid, q_pop;
  item_t    q_in_item, q_out_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ldws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stamp_i    (stamp_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in_item)
  );

  ldws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  ldws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duration_o  (duration_o),
    .short_min_o (short_min_o),
    .short_avg_o (short_avg_o),
    .short_max_o (short_max_o),
    .long_min_o  (long_min_o),
    .long_avg_o  (long_avg_o),
    .long_max_o  (long_max_o),
    .all_min_o   (all_min_o),
    .all_max_o   (all_max_o)
  );

  ldws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire

[rtl/core/ldws_front.sv]
// Front end: accepts input beats, keeps the last timestamp and measures durations.
// Depends on ldws_pkg.
`default_nettype none

module ldws_front import ldws_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire logic  cmd_i,
  input  wire word_t stamp_i,
  input  wire logic  q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  word_t last_stamp_q, last_stamp_d;
  logic  accept;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Classify the beat and take the wrapping difference for a tick
  always_comb begin
    q_item_o.cmd   = cmd_e'(cmd_i);
    q_item_o.stamp = stamp_i;
    if (cmd_e'(cmd_i) == CMD_START) begin
      q_item_o.duration = '0;
    end else begin
      q_item_o.duration = stamp_i - last_stamp_q;
    end
    q_push_o     = accept;
    last_stamp_d = accept ? stamp_i : last_stamp_q;
  end

  // Hold the timestamp of the last accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
    end else begin
      last_stamp_q <= last_stamp_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ldws_fifo.sv]
// Short queue of classified items between front and back end.
// Depends on ldws_pkg.
`default_nettype none

module ldws_fifo import ldws_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ldws_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on ldws_pkg.
`default_nettype none

module ldws_div import ldws_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  word_t               rem_q, quo_q, den_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [DataW:0]      rem_sh;
  logic                fits;

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // Datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? DataW'(rem_sh - {1'b0, den_q}) : rem_sh[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivLastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ldws_back.sv]
// Back end: folds durations into the windows, closes them and drives the result beat.
// Depends on ldws_pkg; uses the serial divider through its request/response structs.
`default_nettype none

module ldws_back import ldws_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_index_i,
  input  wire word_t    cfg_data_i,
  input  wire logic     q_valid_i,
  input  wire item_t    q_item_i,
  output logic          q_pop_o,
  output div_req_t      div_req_o,
  input  wire div_rsp_t div_rsp_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output word_t         duration_o,
  output word_t         short_min_o,
  output word_t         short_avg_o,
  output word_t         short_max_o,
  output word_t         long_min_o,
  output word_t         long_avg_o,
  output word_t         long_max_o,
  output word_t         all_min_o,
  output word_t         all_max_o
);

  state_e state_q, state_d;

  word_t short_period_q, long_period_q;
  word_t period [NumWin];

  item_t it_q;

  word_t win_min_q   [NumWin];
  word_t win_max_q   [NumWin];
  word_t win_sum_q   [NumWin];
  word_t win_count_q [NumWin];
  word_t win_start_q [NumWin];
  word_t rep_min_q   [NumWin];
  word_t rep_avg_q   [NumWin];
  word_t rep_max_q   [NumWin];
  word_t num_q       [NumWin];
  word_t den_q       [NumWin];
  word_t total_min_q, total_max_q;

  logic [NumWin-1:0] pend_q;
  logic              div_run_q;
  win_idx_t          div_sel_q, div_sel_nxt;
  logic              out_valid_q;

  assign period[WinShort] = short_period_q;
  assign period[WinLong]  = long_period_q;

  // Pick the short window first when both wait for a division
  assign div_sel_nxt = pend_q[WinShort] ? WinShort : WinLong;

  assign div_req_o.start = (state_q == ST_DIV) && !div_run_q && (pend_q != '0);
  assign div_req_o.num   = num_q[div_sel_nxt];
  assign div_req_o.den   = den_q[div_sel_nxt];

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i && !out_valid_q;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          state_d = (q_item_i.cmd == CMD_START) ? ST_EMIT : ST_FOLD;
        end
      end
      ST_FOLD:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_DIV;
      ST_DIV: begin
        if (!div_run_q && (pend_q == '0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_period_q <= ShortPeriodRst;
      long_period_q  <= LongPeriodRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_SHORT_PERIOD: short_period_q <= cfg_data_i;
        REG_LONG_PERIOD:  long_period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the item under work
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_item_i;
    end
  end

  // Window statistics, reports and division bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NumWin; w++) begin
        win_min_q[w]   <= AllOnes;
        win_max_q[w]   <= '0;
        win_sum_q[w]   <= '0;
        win_count_q[w] <= '0;
        win_start_q[w] <= '0;
        rep_min_q[w]   <= '0;
        rep_avg_q[w]   <= '0;
        rep_max_q[w]   <= '0;
        num_q[w]       <= '0;
        den_q[w]       <= '0;
      end
      total_min_q <= AllOnes;
      total_max_q <= '0;
      pend_q      <= '0;
      div_run_q   <= 1'b0;
      div_sel_q   <= WinShort;
    end else begin
      unique case (state_q)
        // Fold the duration into both windows and the all-time extremes
        ST_FOLD: begin
          for (int w = 0; w < NumWin; w++) begin
            if (it_q.duration < win_min_q[w]) win_min_q[w] <= it_q.duration;
            if (it_q.duration > win_max_q[w]) win_max_q[w] <= it_q.duration;
            win_sum_q[w]   <= win_sum_q[w] + it_q.duration;
            win_count_q[w] <= win_count_q[w] + 1'b1;
          end
          if (it_q.duration < total_min_q) total_min_q <= it_q.duration;
          if (it_q.duration > total_max_q) total_max_q <= it_q.duration;
        end
        // Record an unset start, or close a window whose span has run out
        ST_CHECK: begin
          for (int w = 0; w < NumWin; w++) begin
            if (win_start_q[w] == '0) begin
              win_start_q[w] <= it_q.stamp;
            end else if ((it_q.stamp - win_start_q[w]) >= period[w]) begin
              if (win_count_q[w] != '0) begin
                rep_min_q[w] <= win_min_q[w];
                rep_max_q[w] <= win_max_q[w];
                num_q[w]     <= win_sum_q[w];
                den_q[w]     <= win_count_q[w];
                pend_q[w]    <= 1'b1;
              end else begin
                rep_min_q[w] <= '0;
                rep_max_q[w] <= '0;
                rep_avg_q[w] <= '0;
              end
              win_min_q[w]   <= AllOnes;
              win_max_q[w]   <= '0;
              win_sum_q[w]   <= '0;
              win_count_q[w] <= '0;
              win_start_q[w] <= it_q.stamp;
            end
          end
        end
        // Launch one division at a time and collect its quotient
        ST_DIV: begin
          if (div_req_o.start) begin
            div_run_q <= 1'b1;
            div_sel_q <= div_sel_nxt;
          end else if (div_run_q && div_rsp_i.done) begin
            rep_avg_q[div_sel_q] <= div_rsp_i.quo;
            pend_q[div_sel_q]    <= 1'b0;
            div_run_q            <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load the result beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      duration_o  <= it_q.duration;
      short_min_o <= rep_min_q[WinShort];
      short_avg_o <= rep_avg_q[WinShort];
      short_max_o <= rep_max_q[WinShort];
      long_min_o  <= rep_min_q[WinLong];
      long_avg_o  <= rep_avg_q[WinLong];
      long_max_o  <= rep_max_q[WinLong];
      all_min_o   <= total_min_q;
      all_max_o   <= total_max_q;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ldws_checker.sv]
// Port-level checker for the loop-duration window statistics block, with its bind.
// Depends on ldws_pkg and on the top level's port names.
`default_nettype none

module ldws_checker import ldws_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  out_valid_o,
  input wire logic  out_stall_i,
  input wire word_t duration_o,
  input wire word_t short_min_o,
  input wire word_t short_max_o,
  input wire word_t long_min_o,
  input wire word_t long_max_o,
  input wire word_t all_min_o,
  input wire word_t all_max_o
);

  // A stalled result beat stays valid and keeps its duration and all-time maximum
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duration_o) && $stable(all_max_o))
    else $error("result beat changed while stalled");

  // Once any duration was seen, the all-time minimum does not exceed the maximum
  a_all_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (all_min_o != AllOnes) |-> all_min_o <= all_max_o)
    else $error("all-time minimum above maximum");

  // Short window report is ordered, or all zeros for an empty window
  a_short_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> short_min_o <= short_max_o)
    else $error("short window minimum above maximum");

  // Long window report is ordered, or all zeros for an empty window
  a_long_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> long_min_o <= long_max_o)
    else $error("long window minimum above maximum");

endmodule

bind loop_duration_window_stats_top ldws_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .duration_o  (duration_o),
  .short_min_o (short_min_o),
  .short_max_o (short_max_o),
  .long_min_o  (long_min_o),
  .long_max_o  (long_max_o),
  .all_min_o   (all_min_o),
  .all_max_o   (all_max_o)
);

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for loop_duration_window_stats_top: directed and random tick/start
// beats, each result compared with a local model of the windowed duration statistics.
// Depends on ldws_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;
  import ldws_pkg::*;

  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAfter   = 150;

  typedef struct packed {
    cmd_e  cmd;
    word_t stamp;
  } beat_t;

  typedef struct packed {
    word_t duration;
    word_t short_min, short_avg, short_max;
    word_t long_min, long_avg, long_max;
    word_t all_min, all_max;
  } stats_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  logic  cfg_index_i = 1'b0;
  word_t cfg_data_i  = '0;
  logic  in_valid_i  = 1'b0;
  logic  cmd_i       = 1'b0;
  word_t stamp_i     = '0;
  logic  out_stall_i = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  word_t duration_o;
  word_t short_min_o, short_avg_o, short_max_o;
  word_t long_min_o, long_avg_o, long_max_o;
  word_t all_min_o, all_max_o;

  loop_duration_window_stats_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .stamp_i     (stamp_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duration_o  (duration_o),
    .short_min_o (short_min_o),
    .short_avg_o (short_avg_o),
    .short_max_o (short_max_o),
    .long_min_o  (long_min_o),
    .long_avg_o  (long_avg_o),
    .long_max_o  (long_max_o),
    .all_min_o   (all_min_o),
    .all_max_o   (all_max_o)
  );

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Statistics model state: periods, windows, reports and all-time extremes
  word_t       period_m [NumWin];
  word_t       last_m;
  word_t       wmin_m [NumWin];
  word_t       wmax_m [NumWin];
  word_t       wsum_m [NumWin];
  word_t       wcnt_m [NumWin];
  word_t       wstart_m [NumWin];
  word_t       rmin_m [NumWin];
  word_t       ravg_m [NumWin];
  word_t       rmax_m [NumWin];
  word_t       tmin_m;
  word_t       tmax_m;
  int unsigned closes_m [NumWin];

  beat_t       beat_q [$];
  beat_t       beat_cur;
  stats_t      stats_due_q [$];
  stats_t      due;
  stats_t      got;
  word_t       now_stamp;
  int unsigned tx_gap, tx_calm, rx_gap, rx_calm, hold_left;
  bit          hold_done;
  int unsigned n_sent, n_ticks, n_checked, n_cycles;
  int unsigned errors;

  function automatic void clear_window_m(int w);
    wmin_m[w] = AllOnes;
    wmax_m[w] = '0;
    wsum_m[w] = '0;
    wcnt_m[w] = '0;
  endfunction

  function automatic void loop_stats_reset();
    int w;
    period_m[WinShort] = ShortPeriodRst;
    period_m[WinLong]  = LongPeriodRst;
    last_m = '0;
    for (w = 0; w < NumWin; w++) begin
      clear_window_m(w);
      wstart_m[w] = '0;
      rmin_m[w]   = '0;
      ravg_m[w]   = '0;
      rmax_m[w]   = '0;
      closes_m[w] = 0;
    end
    tmin_m = AllOnes;
    tmax_m = '0;
  endfunction

  // Advance the model by one beat and return the statistics it leaves behind
  function automatic stats_t loop_stats_step(cmd_e c, word_t s);
    word_t  d;
    stats_t r;
    int     w;
    d = '0;
    if (c == CMD_START) begin
      last_m = s;
    end else begin
      d = s - last_m;
      last_m = s;
      if (d < tmin_m) tmin_m = d;
      if (d > tmax_m) tmax_m = d;
      for (w = 0; w < NumWin; w++) begin
        if (d < wmin_m[w]) wmin_m[w] = d;
        if (d > wmax_m[w]) wmax_m[w] = d;
        wsum_m[w] = wsum_m[w] + d;
        wcnt_m[w] = wcnt_m[w] + 1;
        // An unset start only latches this stamp; otherwise close once the span is reached
        if (wstart_m[w] == '0) begin
          wstart_m[w] = s;
        end else if (word_t'(s - wstart_m[w]) >= period_m[w]) begin
          if (wcnt_m[w] != '0) begin
            rmin_m[w] = wmin_m[w];
            rmax_m[w] = wmax_m[w];
            ravg_m[w] = wsum_m[w] / wcnt_m[w];
          end else begin
            rmin_m[w] = '0;
            rmax_m[w] = '0;
            ravg_m[w] = '0;
          end
          clear_window_m(w);
          wstart_m[w] = s;
          closes_m[w]++;
        end
      end
    end
    r.duration  = d;
    r.short_min = rmin_m[WinShort];
    r.short_avg = ravg_m[WinShort];
    r.short_max = rmax_m[WinShort];
    r.long_min  = rmin_m[WinLong];
    r.long_avg  = ravg_m[WinLong];
    r.long_max  = rmax_m[WinLong];
    r.all_min   = tmin_m;
    r.all_max   = tmax_m;
    return r;
  endfunction

  // Wait between beats: mostly a random gap, with occasional runs of back-to-back beats
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic void compare_word(string name, word_t exp_w, word_t act_w);
    if (exp_w !== act_w) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_w, act_w);
      errors++;
    end
  endfunction

  // Offer pending beats; predict each one at the edge where it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        stats_due_q.push_back(loop_stats_step(cmd_e'(cmd_i), stamp_i));
        n_sent++;
        if (cmd_e'(cmd_i) == CMD_TICK) n_ticks++;
        tx_gap = draw_gap(tx_calm);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          beat_cur = beat_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= beat_cur.cmd;
          stamp_i    <= beat_cur.stamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each result beat against the oldest prediction; stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (stats_due_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got duration %h",
                   $time, duration_o);
          errors++;
        end else begin
          due = stats_due_q.pop_front();
          got = {duration_o, short_min_o, short_avg_o, short_max_o,
                 long_min_o, long_avg_o, long_max_o, all_min_o, all_max_o};
          compare_word("duration", due.duration, got.duration);
          compare_word("short_min", due.short_min, got.short_min);
          compare_word("short_avg", due.short_avg, got.short_avg);
          compare_word("short_max", due.short_max, got.short_max);
          compare_word("long_min", due.long_min, got.long_min);
          compare_word("long_avg", due.long_avg, got.long_avg);
          compare_word("long_max", due.long_max, got.long_max);
          compare_word("all_min", due.all_min, got.all_min);
          compare_word("all_max", due.all_max, got.all_max);
        end
        n_checked++;
        rx_gap = draw_gap(rx_calm);
        // Hold off once for a long stretch so the block backs up into its input
        if (n_checked == HoldAfter && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_beat(cmd_e c, word_t s);
    beat_t b;
    b.cmd   = c;
    b.stamp = s;
    beat_q.push_back(b);
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid_i || stats_due_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_period(reg_e idx, word_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SHORT_PERIOD) period_m[WinShort] = v;
    else period_m[WinLong] = v;
  endtask

  // Drain the block, then reprogram both window spans
  task automatic set_periods(word_t short_span, word_t long_span);
    wait_idle();
    write_period(REG_SHORT_PERIOD, short_span);
    write_period(REG_LONG_PERIOD, long_span);
  endtask

  // Mostly forward-moving stamps, with repeats, jumps, zeros and steps backwards
  task automatic random_beats(int unsigned n, word_t step_max);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) now_stamp = now_stamp + $urandom_range(0, step_max);
      else if (pick < 82) now_stamp = now_stamp + $urandom_range(0, 3);
      else if (pick < 90) now_stamp = $urandom();
      else if (pick < 94) now_stamp = '0;
      else now_stamp = now_stamp - $urandom_range(1, 1000);
      queue_beat(($urandom_range(0, 9) == 0) ? CMD_START : CMD_TICK, now_stamp);
    end
  endtask

  initial begin
    word_t short_span;
    loop_stats_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero stamp keeps windows unset, wrap-around, exact span closes, sum overflow
    queue_beat(CMD_TICK, 32'h0000_0000);
    queue_beat(CMD_TICK, 32'hFFFF_FFFF);
    queue_beat(CMD_START, 32'h8000_0000);
    queue_beat(CMD_TICK, 32'h8000_0000);
    queue_beat(CMD_TICK, 32'h8000_0005);
    queue_beat(CMD_TICK, 32'h800F_4244);
    queue_beat(CMD_TICK, 32'h800F_4245);
    queue_beat(CMD_START, 32'hFFFF_FF00);
    queue_beat(CMD_TICK, 32'h0000_0100);
    queue_beat(CMD_TICK, 32'h0000_0000);
    queue_beat(CMD_TICK, 32'h0000_0010);
    queue_beat(CMD_TICK, 32'h0000_0020);
    queue_beat(CMD_START, 32'h5555_5555);
    queue_beat(CMD_TICK, 32'hAAAA_AAAA);
    queue_beat(CMD_START, 32'hAAAA_AAAA);
    queue_beat(CMD_TICK, 32'h5555_5555);
    queue_beat(CMD_TICK, 32'hFFFF_FFFF);
    queue_beat(CMD_TICK, 32'hFFFF_FFFF);
    now_stamp = 32'hFFFF_FFFF;
    random_beats(300, 250000);

    // Shortest spans: nearly every tick closes both windows
    set_periods(32'd1, 32'd1);
    random_beats(200, 4);

    // Longest spans: big durations wrap the sums, then close exactly at the span
    set_periods(AllOnes, AllOnes);
    queue_beat(CMD_START, 32'h0000_0010);
    queue_beat(CMD_TICK, 32'hC000_0010);
    queue_beat(CMD_TICK, 32'h8000_0010);
    queue_beat(CMD_TICK, 32'h4000_0010);
    wait_idle();
    queue_beat(CMD_TICK, wstart_m[WinShort] - 1);
    queue_beat(CMD_TICK, wstart_m[WinLong] - 1);
    random_beats(150, AllOnes);

    // Zero span: a set window closes on every tick
    set_periods('0, '0);
    random_beats(100, 50);

    set_periods(32'd37, AllOnes);
    random_beats(200, 20);

    // Moderate spans so both windows collect several durations per report
    short_span = $urandom_range(100, 5000);
    set_periods(short_span, short_span * $urandom_range(3, 10));
    random_beats(400, short_span / 3);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("tb: %0d beats sent (%0d ticks), %0d results compared, %0d mismatches",
             n_sent, n_ticks, n_checked, errors);
    $display("tb: short window reported %0d times, long window %0d times, over six span settings",
             closes_m[WinShort], closes_m[WinLong]);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
